// ----- rtl/text_console_cell_writer_core_assert.svh -----
// assertion helpers for the console core
`ifndef TEXT_CONSOLE_CELL_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_CORE_ASSERT_SVH

// same-cycle implication
`define TCCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tccw_pkg.sv -----
package tccw_pkg;

   localparam logic [1:0] MODE_PUT   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_RETURN  = 8'd13;
   localparam logic [7:0] CHAR_BLANK   = 8'h20;
   localparam logic [7:0] RESET_ATTR   = 8'h07;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_word_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [15:0] cell_value;
      logic        scrolled;
   } rsp_word_type;

   typedef struct packed {
      logic valid;
      logic read_hit;
      logic scrolled;
   } rsp_info_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_COPY = 3'b010,
      ST_FILL = 3'b100
   } seq_state_type;

endpackage

// ----- rtl/text_console_cell_writer_core.sv -----
// text console cell writer
// req channel: drive req_word and raise start; the word is taken at a clock edge
// where start is high and busy is low. modes: put character, clear screen, read cell.
// rsp channel: rsp_strobe is high for one cycle with rsp_word; the receiver
// cannot stall, so every result must be taken in that cycle.
// csr channel: csr_data is the text attribute; csr_ready is always high, write
// it only while no word is in flight.
// the strobe comes in the cycle after accept for read, unused mode and a put that does not scroll.
// throughput: one word per cycle while no scroll or clear runs; the single-port write
// of the cell memory sets this.
// a put that scrolls runs a copy pass and a blank fill of the bottom row with busy
// high; clear fills the grid with blanks, also with busy high.
// reset: cursor goes home, attribute returns to 0x07 and the grid is filled with
// blanks in one pass with busy high; no result comes from it.
module text_console_cell_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tccw_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output tccw_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data
);
   import tccw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int AW         = $clog2(CELL_COUNT);

   logic [7:0]    attr_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr, cursor;
   logic [15:0]   mem_wdata, mem_rdata;
   logic [31:0]   cursor_wide;
   rsp_info_type  info;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else if (csr_valid && csr_ready) begin
         attr_ff <= csr_data;
      end
   end

   tccw_seq #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .AW      (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req_word),
      .attribute (attr_ff),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .info      (info),
      .cursor    (cursor)
   );

   tccw_cell_ram #(
      .DEPTH (CELL_COUNT),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign cursor_wide = 32'(cursor);

   assign rsp_strobe               = info.valid;
   assign rsp_word.cursor_position = cursor_wide[10:0];
   assign rsp_word.cell_value      = info.read_hit ? mem_rdata : 16'h0000;
   assign rsp_word.scrolled        = info.scrolled;

endmodule

// ----- rtl/tccw_cell_ram.sv -----
module tccw_cell_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] cells [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells[wr_addr] <= wr_data;
      end
      rd_data_ff <= cells[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tccw_seq.sv -----
`include "text_console_cell_writer_core_assert.svh"

module tccw_seq #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int AW      = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tccw_pkg::req_word_type req,
   input  logic [7:0]            attribute,
   output logic                  mem_we,
   output logic [AW-1:0]         mem_waddr,
   output logic [15:0]           mem_wdata,
   output logic [AW-1:0]         mem_raddr,
   input  logic [15:0]           mem_rdata,
   output tccw_pkg::rsp_info_type info,
   output logic [AW-1:0]         cursor
);
   import tccw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int CNTW       = $clog2(CELL_COUNT + 1);
   localparam int CW         = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
   localparam int RW         = (ROWS > 2) ? $clog2(ROWS) : 1;
   localparam logic [AW-1:0] LAST_ROW_START = AW'(CELL_COUNT - COLUMNS);

   seq_state_type state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            emit_ff, emit_in;
   logic [AW-1:0]   lin_ff, lin_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   rsp_info_type    info_ff, info_in;

   logic        accept, is_put, is_clear, is_read, is_nl, is_cr, is_char;
   logic        col_last, row_last, wrap, scroll_now, in_range;
   logic        copy_last, fill_last, fill_done_emit;
   logic [31:0] idx_wide;
   logic [CNTW-1:0] copy_waddr;

   assign busy     = state_ff != ST_IDLE;
   assign accept   = start && !busy;
   assign is_put   = req.mode == MODE_PUT;
   assign is_clear = req.mode == MODE_CLEAR;
   assign is_read  = req.mode == MODE_READ;
   assign is_nl    = req.char_code == CHAR_NEWLINE;
   assign is_cr    = req.char_code == CHAR_RETURN;
   assign is_char  = !is_nl && !is_cr;

   assign col_last   = col_ff == CW'(COLUMNS - 1);
   assign row_last   = row_ff == RW'(ROWS - 1);
   assign wrap       = is_nl || (is_char && col_last);
   assign scroll_now = accept && is_put && wrap && row_last;

   assign idx_wide = 32'(req.cell_index);
   assign in_range = idx_wide < 32'(CELL_COUNT);

   assign copy_last      = cnt_ff == CNTW'(CELL_COUNT);
   assign fill_last      = cnt_ff == CNTW'(CELL_COUNT - 1);
   assign fill_done_emit = (state_ff == ST_FILL) && fill_last && emit_ff;
   assign copy_waddr     = cnt_ff - CNTW'(COLUMNS + 1);

   // cursor update
   always_comb begin
      lin_in = lin_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (accept && is_put) begin
         if (is_cr) begin
            col_in = '0;
            lin_in = lin_ff - AW'(col_ff);
         end else if (wrap) begin
            col_in = '0;
            if (row_last) begin
               lin_in = LAST_ROW_START;
            end else begin
               row_in = row_ff + RW'(1);
               lin_in = lin_ff + (AW'(COLUMNS) - AW'(col_ff));
            end
         end else begin
            col_in = col_ff + CW'(1);
            lin_in = lin_ff + AW'(1);
         end
      end else if (accept && is_clear) begin
         lin_in = '0;
         col_in = '0;
         row_in = '0;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      emit_in  = emit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_clear) begin
               state_in = ST_FILL;
               cnt_in   = '0;
               emit_in  = 1'b1;
            end else if (scroll_now) begin
               state_in = ST_COPY;
               cnt_in   = CNTW'(COLUMNS);
               emit_in  = 1'b1;
            end
         end
         ST_COPY: begin
            if (copy_last) begin
               state_in = ST_FILL;
               cnt_in   = CNTW'(CELL_COUNT - COLUMNS);
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         ST_FILL: begin
            if (fill_last) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = lin_ff;
      mem_wdata = {attribute, req.char_code};
      mem_raddr = idx_wide[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            mem_we = accept && is_put && is_char;
         end
         ST_COPY: begin
            mem_raddr = cnt_ff[AW-1:0];
            mem_we    = cnt_ff != CNTW'(COLUMNS);
            mem_waddr = copy_waddr[AW-1:0];
            mem_wdata = mem_rdata;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
            mem_wdata = {(emit_ff ? attribute : RESET_ATTR), CHAR_BLANK};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // result tracking
   always_comb begin
      info_in       = info_ff;
      info_in.valid = fill_done_emit || (accept && !(is_clear || scroll_now));
      if (accept) begin
         info_in.read_hit = is_read && in_range;
         info_in.scrolled = scroll_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         cnt_ff   <= '0;
         emit_ff  <= 1'b0;
         lin_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         info_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         emit_ff  <= emit_in;
         lin_ff   <= lin_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         info_ff  <= info_in;
      end
   end

   assign info   = info_ff;
   assign cursor = lin_ff;

   `TCCW_ASSERT_NOW(a_cursor_linear, clock, reset, 1'b1, 32'(lin_ff) == 32'(row_ff) * COLUMNS + 32'(col_ff), "cursor index out of step with row and column")
   `TCCW_ASSERT_NOW(a_cursor_bounds, clock, reset, 1'b1, (32'(col_ff) < COLUMNS) && (32'(row_ff) < ROWS), "cursor outside grid")
   `TCCW_ASSERT_NEXT(a_copy_to_fill, clock, reset, (state_ff == ST_COPY) && copy_last, state_ff == ST_FILL, "copy did not hand over to fill")
   `TCCW_ASSERT_NEXT(a_fill_result, clock, reset, fill_done_emit, info_ff.valid && (state_ff == ST_IDLE), "missing result after fill")
   `TCCW_ASSERT_NOW(a_idle_write, clock, reset, (state_ff == ST_IDLE) && mem_we, accept && is_put && is_char, "stray write while idle")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import tccw_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 12_000_000;

   class console_scoreboard;
      logic [15:0]  screen [CELL_COUNT];
      int unsigned  cursor;
      logic [7:0]   attribute;
      rsp_word_type predicted_rsp [$];
      int           errors;

      function new();
         attribute = RESET_ATTR;
         cursor = 0;
         errors = 0;
         foreach (screen[i]) screen[i] = {RESET_ATTR, CHAR_BLANK};
      endfunction

      function void set_attribute(logic [7:0] a);
         attribute = a;
      endfunction

      function int pending();
         return predicted_rsp.size();
      endfunction

      task report(string msg);
         $display("[%0t] %s", $time, msg);
         errors++;
      endtask

      // work out the result of one accepted word and update the console state
      function void apply_word(req_word_type w);
         int unsigned  pos;
         logic [15:0]  value;
         logic         rolled;
         rsp_word_type r;
         pos = cursor;
         value = '0;
         rolled = 1'b0;
         if (w.mode == MODE_PUT) begin
            if (w.char_code == CHAR_NEWLINE) begin
               pos = pos + COLUMNS - (pos % COLUMNS);
            end else if (w.char_code == CHAR_RETURN) begin
               pos = pos - (pos % COLUMNS);
            end else begin
               screen[pos] = {attribute, w.char_code};
               pos = pos + 1;
            end
            if (pos >= CELL_COUNT) begin
               for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
               for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
                  screen[i] = {attribute, CHAR_BLANK};
               end
               pos = pos - COLUMNS;
               rolled = 1'b1;
            end
         end else if (w.mode == MODE_CLEAR) begin
            foreach (screen[i]) screen[i] = {attribute, CHAR_BLANK};
            pos = 0;
         end else if (w.mode == MODE_READ) begin
            if (w.cell_index < CELL_COUNT) value = screen[w.cell_index];
         end
         cursor = pos;
         r.cursor_position = pos[10:0];
         r.cell_value = value;
         r.scrolled = rolled;
         predicted_rsp.push_back(r);
      endfunction

      task compare_rsp(rsp_word_type got);
         rsp_word_type want;
         if (predicted_rsp.size() == 0) begin
            report($sformatf("result with none expected: cursor %0d value %h scrolled %0b",
                             got.cursor_position, got.cell_value, got.scrolled));
            return;
         end
         want = predicted_rsp.pop_front();
         if (got.cursor_position !== want.cursor_position) begin
            report($sformatf("cursor_position got %0d want %0d",
                             got.cursor_position, want.cursor_position));
         end
         if (got.cell_value !== want.cell_value) begin
            report($sformatf("cell_value got %h want %h", got.cell_value, want.cell_value));
         end
         if (got.scrolled !== want.scrolled) begin
            report($sformatf("scrolled got %b want %b", got.scrolled, want.scrolled));
         end
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data = '0;

   console_scoreboard board = new();
   int sender_idle = 37;
   int words_sent = 0;
   int cycle_count = 0;

   text_console_cell_writer_core #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.compare_rsp(rsp_word);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, board.pending());
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic req_word_type make_word(logic [1:0] m, logic [7:0] c, logic [10:0] idx);
      req_word_type w;
      w.mode = m;
      w.char_code = c;
      w.cell_index = idx;
      return w;
   endfunction

   function automatic req_word_type put_word(logic [7:0] c);
      return make_word(MODE_PUT, c, 11'($urandom_range(2047)));
   endfunction

   function automatic req_word_type read_word(logic [10:0] a);
      return make_word(MODE_READ, 8'($urandom_range(255)), a);
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < sender_idle) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      board.apply_word(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      @(negedge clock);
   endtask

   task automatic write_attribute(input logic [7:0] a);
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0 || busy);
      repeat (2) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= a;
      do @(posedge clock); while (!csr_ready);
      board.set_attribute(a);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_segment(input int quota);
      int stop_at;
      int pick;
      int len;
      logic [7:0] c;
      logic [10:0] a;
      stop_at = words_sent + quota;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            // a line of text, wrapping when long
            len = $urandom_range(1, 90);
            repeat (len) begin
               if ($urandom_range(3) == 0) c = 8'($urandom_range(255));
               else c = 8'($urandom_range(126, 32));
               send_word(put_word(c));
            end
            send_word(put_word(($urandom_range(9) < 7) ? CHAR_NEWLINE : CHAR_RETURN));
         end else if (pick < 60) begin
            repeat ($urandom_range(1, 30)) send_word(put_word(CHAR_NEWLINE));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 8)) begin
               len = $urandom_range(9);
               if (len == 0) a = 11'($urandom_range(2047, CELL_COUNT));
               else if (len < 6) begin
                  a = 11'((board.cursor + CELL_COUNT - 1 - $urandom_range(2 * COLUMNS))
                          % CELL_COUNT);
               end else a = 11'($urandom_range(CELL_COUNT - 1));
               send_word(read_word(a));
            end
         end else if (pick < 89) begin
            send_word(make_word(MODE_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047))));
         end else if (pick < 94) begin
            send_word(make_word(MODE_UNUSED, 8'($urandom_range(255)), 11'($urandom_range(2047))));
         end else if (pick < 96) begin
            hold_until_drained();
         end else begin
            send_word(read_word(11'($urandom_range(2047))));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words on the reset attribute
      send_word(read_word(11'd0));
      send_word(read_word(11'(CELL_COUNT - 1)));
      send_word(read_word(11'(CELL_COUNT)));
      send_word(read_word(11'h7FF));
      send_word(make_word(MODE_UNUSED, 8'hFF, 11'h7FF));
      send_word(put_word(8'h00));
      send_word(put_word(8'hFF));
      send_word(put_word(8'h08));
      send_word(put_word(CHAR_RETURN));
      send_word(put_word(8'h41));
      send_word(put_word(CHAR_NEWLINE));
      send_word(put_word(CHAR_NEWLINE));
      send_word(read_word(11'd0));
      send_word(read_word(11'd1));
      send_word(read_word(11'd2));
      send_word(make_word(MODE_CLEAR, 8'hFF, 11'h7FF));
      send_word(read_word(11'd1));

      for (int seg = 0; seg < 6; seg++) begin
         sender_idle = (seg < 2) ? 37 : (seg < 4) ? 57 : 0;
         if (seg == 0) write_attribute(8'h00);
         else if (seg == 1) write_attribute(8'hFF);
         else write_attribute(8'($urandom_range(255)));
         run_segment(200);
      end

      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (20) @(posedge clock);
      if (board.pending() != 0) board.report("expected results never arrived");
      if (board.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tccw_pkg.sv
rtl/tccw_cell_ram.sv
rtl/tccw_seq.sv
rtl/text_console_cell_writer_core.sv
bench/tb_top.sv
